FILE: design/glpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpf_pkg
// Shared constants for the grid local peak finder: field widths, parameter
// defaults, register reset values and register indexes.
// ----------------------------------------------------------------------------
package glpf_pkg;

   // fixed field widths
   localparam int ROW_BITS       = 10;
   localparam int GRID_COLS_BITS = 6;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;

   // parameter defaults
   localparam int MAX_COLS_DEF    = 32;
   localparam int HEIGHT_BITS_DEF = 16;
   localparam int LS_DEPTH_DEF    = 2 * MAX_COLS_DEF;

   // register reset values
   localparam logic [ROW_BITS-1:0]       GRID_ROWS_RST = ROW_BITS'(10);
   localparam logic [GRID_COLS_BITS-1:0] GRID_COLS_RST = GRID_COLS_BITS'(5);

   // register indexes, decoded from paddr[2]
   localparam logic REG_GRID_ROWS = 1'b0;
   localparam logic REG_GRID_COLS = 1'b1;

endpackage

FILE: design/glpf_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpf_line_store
// Two-row line store: one write port, one read port, registered read data
// (valid in the cycle after the read). Contents are undefined until written.
// ----------------------------------------------------------------------------
module glpf_line_store
   import glpf_pkg::*;
#(
   parameter int DEPTH     = LS_DEPTH_DEF,
   parameter int DATA_BITS = HEIGHT_BITS_DEF,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not reading
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/grid_local_peak_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_peak_finder
// Four-neighbor local maximum detection over a raster-order height stream.
// ----------------------------------------------------------------------------
// Heights arrive one per transaction in raster order; each sample decides the
// cell directly above it, and the last sample of a frame also decides every
// cell of the final row. A cell is a peak when it is not less than its up,
// down, left and right neighbors (outside the grid counts as 0). Peaks come
// out in row-then-column order; run_last marks the final peak caused by one
// input transaction. All neighbor reads go through the single read port of a
// two-row line store, one read per cycle, so the block handles one sample at
// a time: a first-row sample is only written back and wrapped up, any later
// sample takes 4 line store reads plus compare, write-back and wrap-up, and
// the last sample of a frame adds 4 reads and a compare per column of the
// final row. Result back-pressure stalls the block whenever a held peak has to
// move into the output register while that register still holds an unaccepted
// transaction. The line store needs no clearing pass: only entries written in
// the current frame are ever used. Any configuration write restarts the frame.
// ----------------------------------------------------------------------------
module grid_local_peak_finder
   import glpf_pkg::*;
#(
   parameter int MAX_COLS    = MAX_COLS_DEF,
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [HEIGHT_BITS-1:0]    req_height,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ROW_BITS-1:0]              rsp_peak_row,
   output logic [$clog2(MAX_COLS)-1:0]      rsp_peak_col,
   output logic                             rsp_run_last,
   // configuration port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [CSR_ADDR_BITS-1:0]         paddr,
   input  logic [CSR_DATA_BITS-1:0]         pwdata,
   output logic [CSR_DATA_BITS-1:0]         prdata,
   output logic                             pready
);

   localparam int COL_BITS  = $clog2(MAX_COLS);
   localparam int CNT_BITS  = $clog2(MAX_COLS + 1);
   localparam int DEPTH     = 2 * MAX_COLS;
   localparam int ADDR_BITS = $clog2(DEPTH);

   // evaluation phases: reads issued in TOP..RIGHT, compare in CMP
   localparam logic [2:0] PH_TOP   = 3'd0;
   localparam logic [2:0] PH_CTR   = 3'd1;
   localparam logic [2:0] PH_LEFT  = 3'd2;
   localparam logic [2:0] PH_RIGHT = 3'd3;
   localparam logic [2:0] PH_CMP   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // control registers
   state_type                   state_ff,      state_in;
   logic [ROW_BITS-1:0]         grid_rows_ff,  grid_rows_in;
   logic [GRID_COLS_BITS-1:0]   grid_cols_ff,  grid_cols_in;
   logic [ROW_BITS-1:0]         row_idx_ff,    row_idx_in;
   logic [COL_BITS-1:0]         col_idx_ff,    col_idx_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic                        rsp_valid_ff,  rsp_valid_in;

   // working registers
   logic [2:0]                  phase_ff,      phase_in;
   logic                        flush_ff,      flush_in;
   logic signed [HEIGHT_BITS-1:0] h_ff,        h_in;
   logic [ROW_BITS-1:0]         r_ff,          r_in;
   logic [COL_BITS-1:0]         c_ff,          c_in;
   logic [ROW_BITS-1:0]         ev_row_ff,     ev_row_in;
   logic [COL_BITS-1:0]         ev_col_ff,     ev_col_in;
   logic                        top_ok_ff,     top_ok_in;
   logic signed [HEIGHT_BITS-1:0] top_ff,      top_in;
   logic signed [HEIGHT_BITS-1:0] ctr_ff,      ctr_in;
   logic signed [HEIGHT_BITS-1:0] left_ff,     left_in;
   logic [ROW_BITS-1:0]         pend_row_ff,   pend_row_in;
   logic [COL_BITS-1:0]         pend_col_ff,   pend_col_in;
   logic [ROW_BITS-1:0]         rsp_row_ff,    rsp_row_in;
   logic [COL_BITS-1:0]         rsp_col_ff,    rsp_col_in;
   logic                        rsp_last_ff,   rsp_last_in;

   // line store port signals
   logic                        ls_wr_en;
   logic [ADDR_BITS-1:0]        ls_wr_addr;
   logic                        ls_rd_en;
   logic [ADDR_BITS-1:0]        ls_rd_addr;
   logic [HEIGHT_BITS-1:0]      ls_rd_data;

   // misc combinational
   logic [ROW_BITS-1:0]         eff_rows;
   logic [CNT_BITS-1:0]         eff_cols;
   logic                        req_accept;
   logic                        cfg_write;
   logic                        out_free;
   logic                        wrap;
   logic [ROW_BITS-1:0]         acc_r;
   logic [COL_BITS-1:0]         acc_c;
   logic [CNT_BITS-1:0]         ev_col_next;
   logic [CNT_BITS-1:0]         c_next;
   logic                        left_ok;
   logic                        right_ok;
   logic                        row_end;
   logic                        frame_end;
   logic                        ev_bank;
   logic [COL_BITS-1:0]         rd_col;
   logic                        rd_bank;
   logic signed [HEIGHT_BITS-1:0] top_v, left_v, right_v, bottom_v;
   logic                        is_peak;

   // address of (bank, column) in the line store
   function automatic logic [ADDR_BITS-1:0] ls_addr(input logic bank,
                                                     input logic [COL_BITS-1:0] col);
      logic [ADDR_BITS-1:0] base;
      base = bank ? ADDR_BITS'(MAX_COLS) : '0;
      return base + ADDR_BITS'(col);
   endfunction

   // effective frame size
   always_comb begin
      eff_rows = (grid_rows_ff == '0) ? ROW_BITS'(1) : grid_rows_ff;
      if (grid_cols_ff == '0) begin
         eff_cols = CNT_BITS'(1);
      end else if (grid_cols_ff > GRID_COLS_BITS'(MAX_COLS)) begin
         eff_cols = CNT_BITS'(MAX_COLS);
      end else begin
         eff_cols = CNT_BITS'(grid_cols_ff);
      end
   end

   // handshakes
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cfg_write  = psel && penable && pwrite;

   // position of the accepted sample, restarting if out of frame
   always_comb begin
      wrap  = (row_idx_ff >= eff_rows) || (CNT_BITS'(col_idx_ff) >= eff_cols);
      acc_r = wrap ? '0 : row_idx_ff;
      acc_c = wrap ? '0 : col_idx_ff;
   end

   // neighbor availability for the cell under evaluation
   assign ev_col_next = CNT_BITS'(ev_col_ff) + CNT_BITS'(1);
   assign left_ok     = (ev_col_ff != '0);
   assign right_ok    = (ev_col_next < eff_cols);
   assign ev_bank     = ev_row_ff[0];

   // sample position bookkeeping
   assign c_next    = CNT_BITS'(c_ff) + CNT_BITS'(1);
   assign row_end   = (c_next == eff_cols);
   assign frame_end = row_end && ((r_ff + ROW_BITS'(1)) == eff_rows);

   // read address sequencing: top from the other bank, rest from the cell's bank
   always_comb begin
      rd_bank = ev_bank;
      rd_col  = ev_col_ff;
      case (phase_ff)
         PH_TOP: begin
            rd_bank = !ev_bank;
         end
         PH_LEFT: begin
            rd_col = left_ok ? (ev_col_ff - COL_BITS'(1)) : ev_col_ff;
         end
         PH_RIGHT: begin
            rd_col = right_ok ? COL_BITS'(ev_col_next) : ev_col_ff;
         end
         default: begin
            rd_col = ev_col_ff;
         end
      endcase
      ls_rd_en   = (state_ff == ST_EVAL) && (phase_ff != PH_CMP);
      ls_rd_addr = ls_addr(rd_bank, rd_col);
   end

   // write-back of the sample
   assign ls_wr_en   = (state_ff == ST_WRITE);
   assign ls_wr_addr = ls_addr(r_ff[0], c_ff);

   // peak compare, right neighbor straight from the read port
   always_comb begin
      top_v    = top_ok_ff ? top_ff : '0;
      left_v   = left_ok ? left_ff : '0;
      right_v  = right_ok ? $signed(ls_rd_data) : '0;
      bottom_v = flush_ff ? '0 : h_ff;
      is_peak  = (ctr_ff >= top_v) && (ctr_ff >= left_v) &&
                 (ctr_ff >= right_v) && (ctr_ff >= bottom_v);
   end

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      grid_rows_in  = grid_rows_ff;
      grid_cols_in  = grid_cols_ff;
      row_idx_in    = row_idx_ff;
      col_idx_in    = col_idx_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      phase_in      = phase_ff;
      flush_in      = flush_ff;
      h_in          = h_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      ev_row_in     = ev_row_ff;
      ev_col_in     = ev_col_ff;
      top_ok_in     = top_ok_ff;
      top_in        = top_ff;
      ctr_in        = ctr_ff;
      left_in       = left_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               h_in      = req_height;
               r_in      = acc_r;
               c_in      = acc_c;
               flush_in  = 1'b0;
               phase_in  = PH_TOP;
               ev_row_in = acc_r - ROW_BITS'(1);
               ev_col_in = acc_c;
               top_ok_in = (acc_r >= ROW_BITS'(2));
               state_in  = (acc_r != '0) ? ST_EVAL : ST_WRITE;
            end
         end

         ST_EVAL: begin
            // capture read data in the cycle after each read
            case (phase_ff)
               PH_CTR:   top_in  = $signed(ls_rd_data);
               PH_LEFT:  ctr_in  = $signed(ls_rd_data);
               PH_RIGHT: left_in = $signed(ls_rd_data);
               default: begin
               end
            endcase
            if (phase_ff != PH_CMP) begin
               phase_in = phase_ff + 3'd1;
            end else if (!(is_peak && pend_valid_ff) || out_free) begin
               // a new peak pushes the held one out as not-last
               if (is_peak) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_row_in   = pend_row_ff;
                     rsp_col_in   = pend_col_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_row_in   = ev_row_ff;
                  pend_col_in   = ev_col_ff;
               end
               if (!flush_ff) begin
                  state_in = ST_WRITE;
               end else if (right_ok) begin
                  ev_col_in = COL_BITS'(ev_col_next);
                  phase_in  = PH_TOP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_WRITE: begin
            if (frame_end) begin
               row_idx_in = '0;
               col_idx_in = '0;
               flush_in   = 1'b1;
               ev_row_in  = r_ff;
               ev_col_in  = '0;
               top_ok_in  = (r_ff != '0);
               phase_in   = PH_TOP;
               state_in   = ST_EVAL;
            end else if (row_end) begin
               col_idx_in = '0;
               row_idx_in = r_ff + ROW_BITS'(1);
               state_in   = ST_FINISH;
            end else begin
               col_idx_in = COL_BITS'(c_next);
               state_in   = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // the held peak is the last one of this transaction
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = pend_row_ff;
               rsp_col_in    = pend_col_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes restart the frame
      if (cfg_write) begin
         unique case (paddr[2])
            REG_GRID_ROWS: grid_rows_in = pwdata[ROW_BITS-1:0];
            REG_GRID_COLS: grid_cols_in = pwdata[GRID_COLS_BITS-1:0];
            default: begin
            end
         endcase
         row_idx_in = '0;
         col_idx_in = '0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         grid_rows_ff  <= GRID_ROWS_RST;
         grid_cols_ff  <= GRID_COLS_RST;
         row_idx_ff    <= '0;
         col_idx_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         grid_rows_ff  <= grid_rows_in;
         grid_cols_ff  <= grid_cols_in;
         row_idx_ff    <= row_idx_in;
         col_idx_ff    <= col_idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      phase_ff    <= phase_in;
      flush_ff    <= flush_in;
      h_ff        <= h_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      ev_row_ff   <= ev_row_in;
      ev_col_ff   <= ev_col_in;
      top_ok_ff   <= top_ok_in;
      top_ff      <= top_in;
      ctr_ff      <= ctr_in;
      left_ff     <= left_in;
      pend_row_ff <= pend_row_in;
      pend_col_ff <= pend_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   // line store
   glpf_line_store #(
      .DEPTH     (DEPTH),
      .DATA_BITS (HEIGHT_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ls_wr_en),
      .wr_addr (ls_wr_addr),
      .wr_data (h_ff),
      .rd_en   (ls_rd_en),
      .rd_addr (ls_rd_addr),
      .rd_data (ls_rd_data)
   );

   // outputs
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_peak_row = rsp_row_ff;
   assign rsp_peak_col = rsp_col_ff;
   assign rsp_run_last = rsp_last_ff;
   assign pready       = 1'b1;
   assign prdata       = (paddr[2] == REG_GRID_COLS) ? CSR_DATA_BITS'(grid_cols_ff)
                                                     : CSR_DATA_BITS'(grid_rows_ff);

   // checks
   a_pend_clear_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held peak left over after a transaction");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (phase_ff <= PH_CMP))
      else $error("evaluation phase out of range");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("input not stalled after a transaction");

   a_write_after_eval: assert property (@(posedge clock) disable iff (reset)
      ls_wr_en |-> (($past(state_ff) == ST_EVAL) || ($past(state_ff) == ST_IDLE)))
      else $error("line store write out of sequence");

endmodule
